FILE: rtl/bzcq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bzcq_pkg
// Shared types and codes for the back-EMF zero-cross qualifier.
// ----------------------------------------------------------------------------
package bzcq_pkg;

    // operation codes (s_axis tuser)
    localparam logic [1:0] OP_START_WAIT   = 2'd0;
    localparam logic [1:0] OP_SAMPLE       = 2'd1;
    localparam logic [1:0] OP_DIRECT_START = 2'd2;

    // result status codes (m_axis tuser)
    localparam logic [2:0] ST_STARTED  = 3'd0;
    localparam logic [2:0] ST_WAITING  = 3'd1;
    localparam logic [2:0] ST_ACCEPTED = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    localparam logic [7:0] CNT_MAX      = 8'd255;
    localparam logic [7:0] NEED_MIN     = 8'd1;
    localparam logic [7:0] NEED_CEIL    = 8'd20;
    localparam logic [7:0] NEED_STARTUP = 8'd27;

    typedef struct packed {
        logic [1:0] op;
        logic       wait_high;
        logic       brake_reverse;
        logic       spin_up;
        logic       early_run;
        logic       rpm_fast;
        logic [7:0] period_high;
        logic [7:0] direct_count;
        logic       comparator_level;
        logic       timeout_seen;
    } t_item;

    typedef struct packed {
        logic       expected_level;
        logic [7:0] needed_count;
        logic [7:0] ceiling_count;
        logic [7:0] read_count;
        logic [7:0] stable_count;
        logic       demag_seen;
        logic       expired;
    } t_state;

    typedef struct packed {
        logic [2:0] status;
        logic       demag_flag;
        logic [7:0] stable_count_out;
        logic [7:0] needed_count_out;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/bzcq_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bzcq_eval
// Next-state and result logic for one item against the qualifier state.
// ----------------------------------------------------------------------------
module bzcq_eval (
    input  bzcq_pkg::t_item   i_item,
    input  bzcq_pkg::t_state  i_state,
    input  wire logic         i_fast_clock,
    output bzcq_pkg::t_state  o_state,
    output bzcq_pkg::t_result o_result
);
    import bzcq_pkg::*;

    logic [7:0] half_period;
    logic [7:0] need_base;
    logic [7:0] ceil_base;
    logic [7:0] need_scaled;
    logic [7:0] ceil_scaled;
    logic [7:0] read_inc;
    logic [7:0] stable_inc;
    logic [7:0] direct_need;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 8'd1;
    endfunction

    assign half_period = {1'b0, i_item.period_high[7:1]};
    assign read_inc    = sat_inc(i_state.read_count);
    assign stable_inc  = sat_inc(i_state.stable_count);
    assign direct_need = (i_item.direct_count == 8'd0) ? NEED_MIN : i_item.direct_count;

    always_comb begin
        priority if (i_item.rpm_fast) begin
            need_base = NEED_MIN;
            ceil_base = NEED_MIN;
        end else if (i_item.spin_up) begin
            need_base = NEED_STARTUP;
            ceil_base = NEED_STARTUP;
        end else if (half_period == 8'd0) begin
            need_base = NEED_MIN;
            ceil_base = NEED_CEIL;
        end else if (half_period > NEED_CEIL) begin
            need_base = NEED_CEIL;
            ceil_base = NEED_CEIL;
        end else begin
            need_base = half_period;
            ceil_base = NEED_CEIL;
        end
    end

    // base counts are at most 27, so doubling never wraps to zero
    assign need_scaled = i_fast_clock ? {need_base[6:0], 1'b0} : need_base;
    assign ceil_scaled = i_fast_clock ? {ceil_base[6:0], 1'b0} : ceil_base;

    always_comb begin
        o_state         = i_state;
        o_result.status = ST_WAITING;
        unique case (i_item.op)
            OP_START_WAIT: begin
                o_state.needed_count   = need_scaled;
                o_state.ceiling_count  = ceil_scaled;
                o_state.expected_level = i_item.wait_high ^ i_item.brake_reverse;
                o_state.demag_seen     = ~(i_item.spin_up | i_item.early_run);
                o_state.read_count     = 8'd0;
                o_state.stable_count   = 8'd0;
                o_state.expired        = 1'b0;
                o_result.status        = ST_STARTED;
            end
            OP_DIRECT_START: begin
                o_state.needed_count   = direct_need;
                o_state.ceiling_count  = direct_need;
                o_state.expected_level = i_item.wait_high;
                o_state.demag_seen     = 1'b1;
                o_state.read_count     = 8'd0;
                o_state.stable_count   = 8'd0;
                o_state.expired        = 1'b0;
                o_result.status        = ST_STARTED;
            end
            OP_SAMPLE: begin
                priority if (i_state.expired) begin
                    o_result.status = ST_TIMEOUT;
                end else if (i_item.timeout_seen && (i_state.read_count != 8'd0)) begin
                    o_state.expired = 1'b1;
                    o_result.status = ST_TIMEOUT;
                end else if (i_item.comparator_level != i_state.expected_level) begin
                    o_state.read_count   = read_inc;
                    o_state.demag_seen   = 1'b0;
                    o_state.stable_count = 8'd0;
                    o_result.status      = ST_REJECTED;
                end else begin
                    o_state.read_count   = read_inc;
                    o_state.stable_count = stable_inc;
                    o_result.status      = (stable_inc < i_state.needed_count) ?
                                           ST_WAITING : ST_ACCEPTED;
                end
            end
            default: begin
                // unused opcode: no state change
                o_result.status = ST_WAITING;
            end
        endcase
        o_result.demag_flag       = o_state.demag_seen;
        o_result.stable_count_out = o_state.stable_count;
        o_result.needed_count_out = o_state.needed_count;
    end

endmodule
`default_nettype wire

FILE: rtl/bemf_zero_cross_qualifier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bemf_zero_cross_qualifier_core
// Back-EMF comparator sample qualifier: start-wait and direct-start setup, stable-count
// qualification, demag flag and sticky timeout.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata / wdata                          | tuser
//  s_axis    | in  | wait/brake/phase/rpm/period/count/comp | op
//  m_axis    | out | demag, stable count, needed count      | status
//  cfg       | in  | fast_clock                             | -
//
//  One item per cycle sustained while m_axis accepts; each item passes the input
//  register, then the result register, with the state update done between them.
//  Synchronous active-low reset; no clearing pass.
//  An m_axis stall holds the result; one more item waits in the input
//  register, then s_axis tready drops.
// ----------------------------------------------------------------------------
module bemf_zero_cross_qualifier_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,     // [0] fast_clock
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] wait_high, [1] brake_reverse, [2] spin_up,
    // [3] early_run, [4] rpm_fast, [12:5] period_high,
    // [20:13] direct_count, [21] comparator_level, [22] timeout_seen
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,      // [1:0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] demag_flag, [8:1] stable_count_out, [16:9] needed_count_out
    output logic [23:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser       // [2:0] status
);
    import bzcq_pkg::*;

    logic    r_fast_clock;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    bzcq_eval u_eval (
        .i_item       (r_in),
        .i_state      (r_state),
        .i_fast_clock (r_fast_clock),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_clock <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_fast_clock <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{expected_level: 1'b0, needed_count: NEED_MIN,
                             ceiling_count: NEED_MIN, read_count: 8'd0,
                             stable_count: 8'd0, demag_seen: 1'b1, expired: 1'b0};
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.op               <= s_axis_tuser;
            r_in.wait_high        <= s_axis_tdata[0];
            r_in.brake_reverse    <= s_axis_tdata[1];
            r_in.spin_up          <= s_axis_tdata[2];
            r_in.early_run        <= s_axis_tdata[3];
            r_in.rpm_fast         <= s_axis_tdata[4];
            r_in.period_high      <= s_axis_tdata[12:5];
            r_in.direct_count     <= s_axis_tdata[20:13];
            r_in.comparator_level <= s_axis_tdata[21];
            r_in.timeout_seen     <= s_axis_tdata[22];
        end
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {7'd0, r_out.needed_count_out, r_out.stable_count_out,
                            r_out.demag_flag};

`ifndef ASSERT_OFF
    a_counts_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.needed_count != 8'd0) && (r_state.ceiling_count != 8'd0))
        else $error("needed or ceiling count is zero");

    a_expired_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.expired |-> (r_state.read_count != 8'd0))
        else $error("timeout latched with no sample read");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced item lost before result register");

    a_accept_meets_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_ACCEPTED)) |->
        (m_axis_tdata[8:1] >= m_axis_tdata[16:9]))
        else $error("accepted with stable count below needed count");
`endif

endmodule
`default_nettype wire
